>>> sv/clcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package clcs_pkg;

   localparam int MAX_WIDTH_DEFAULT = 1024;
   localparam int MIN_WIDTH         = 256;
   localparam int QUEUE_DEPTH       = 4;

   localparam int PALETTE_BITS    = 64;
   localparam int LINE_WIDTH_BITS = 11;
   localparam int CSR_INDEX_BITS  = 2;

   localparam logic [CSR_INDEX_BITS-1:0] REG_PALETTE    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LINE_WIDTH = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ZIGZAG     = 2'd2;

   localparam logic [7:0] BLANK_SAMPLE = 8'h40;
   localparam int CHROMA_LIMIT = 127;
   localparam int LUMA_MIN     = 64;
   localparam int LUMA_MAX     = 224;

   typedef struct packed {
      logic [PALETTE_BITS-1:0]    palette;
      logic [LINE_WIDTH_BITS-1:0] line_width;
      logic                       zigzag;
   } cfg_type;

   // one composite sample push for the back end; flush stands for three blank pushes
   typedef struct packed {
      logic [7:0] sample;
      logic       flush;
      logic       first;
      logic       colour;
   } entry_type;

endpackage

`default_nettype wire

>>> sv/clcs_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface clcs_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] pixel_index;

   modport source (output valid, output pixel_index, input ready);
   modport sink (input valid, input pixel_index, output ready);
endinterface

interface clcs_rsp_if;
   logic              valid;
   logic              ready;
   logic [8:0]        pair_position;
   logic [7:0]        luma_code;
   logic signed [7:0] chroma_value;
   logic              colour_mode;
   logic              last;

   modport source (output valid, output pair_position, output luma_code,
                   output chroma_value, output colour_mode, output last, input ready);
   modport sink (input valid, input pair_position, input luma_code,
                 input chroma_value, input colour_mode, input last, output ready);
endinterface

`default_nettype wire

>>> sv/clcs_front.sv
`timescale 1ns / 1ps
`default_nettype none

module clcs_front #(
   parameter int MAX_WIDTH = clcs_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   clcs_req_if.sink                 req,
   input  wire clcs_pkg::cfg_type   cfg,
   input  wire logic                queue_full,
   output logic                     entry_valid,
   output clcs_pkg::entry_type      entry
);

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int PW = $clog2(MAX_WIDTH);
   localparam int CW = (WW > clcs_pkg::LINE_WIDTH_BITS) ? WW : clcs_pkg::LINE_WIDTH_BITS;
   localparam logic [CW-1:0] W_HI = CW'(MAX_WIDTH & ~1);
   localparam logic [CW-1:0] W_LO = CW'(clcs_pkg::MIN_WIDTH);

   function automatic logic [6:0] spread(input logic [3:0] code);
      return {code[3], 1'b0, code[2], 1'b0, code[1], 1'b0, code[0]};
   endfunction

   logic [PW-1:0] pos_ff, pos_in;
   logic [WW-1:0] width_ff, width_in;
   logic          zig_ff, zig_in;
   logic [6:0]    half_ff, half_in;
   logic          colour_ff, colour_in;

   logic          accept;
   logic [CW-1:0] lw_even, w_new;
   logic          line_start;
   logic [WW-1:0] w_cur, pos_x, pair_lo, pair_hi;
   logic          z_cur, in_pairs, second, first_pair, eol;
   logic [6:0]    v;
   logic [7:0]    p;

   assign req.ready = !queue_full;
   assign accept    = req.valid && !queue_full;

   always_comb begin
      lw_even    = CW'({cfg.line_width[clcs_pkg::LINE_WIDTH_BITS-1:1], 1'b0});
      w_new      = (lw_even < W_LO) ? W_LO : ((lw_even > W_HI) ? W_HI : lw_even);
      line_start = (pos_ff == '0);
      w_cur      = line_start ? w_new[WW-1:0] : width_ff;
      z_cur      = line_start ? cfg.zigzag : zig_ff;
      pos_x      = WW'(pos_ff);
      pair_lo    = WW'(z_cur) + WW'(1);
      pair_hi    = w_cur - WW'(2) - WW'(z_cur);
      in_pairs   = (pos_x >= pair_lo) && (pos_x <= pair_hi);
      second     = (pos_ff[0] == z_cur);
      first_pair = (pos_x == WW'(z_cur) + WW'(2));
      eol        = (pos_x >= w_cur - WW'(1));

      v = spread(cfg.palette[{req.pixel_index, 2'b00} +: 4]);
      p = {half_ff, 1'b0} | {1'b0, v};

      colour_in = ((line_start ? 1'b0 : colour_ff) |
                   ((pos_ff[PW-1:1] == '0) && (v != '0)));

      entry_valid   = accept && (eol || (in_pairs && second));
      entry.sample  = (eol || (p == '0)) ? clcs_pkg::BLANK_SAMPLE : p;
      entry.flush   = eol;
      entry.first   = first_pair && !eol;
      entry.colour  = colour_in;

      pos_in   = eol ? '0 : pos_ff + PW'(1);
      width_in = w_cur;
      zig_in   = z_cur;
      half_in  = (in_pairs && !second) ? v : half_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         width_ff  <= WW'(clcs_pkg::MIN_WIDTH);
         zig_ff    <= 1'b0;
         half_ff   <= '0;
         colour_ff <= 1'b0;
      end else if (accept) begin
         pos_ff    <= pos_in;
         width_ff  <= width_in;
         zig_ff    <= zig_in;
         half_ff   <= half_in;
         colour_ff <= colour_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/clcs_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module clcs_queue #(
   parameter int DEPTH = clcs_pkg::QUEUE_DEPTH
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire clcs_pkg::entry_type push_data,
   output logic                     full,
   input  wire logic                pop,
   output logic                     head_valid,
   output clcs_pkg::entry_type      head
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   clcs_pkg::entry_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [NW-1:0] count_ff, count_in;

   assign full       = (count_ff == NW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ff];

   always_comb begin
      wr_in    = push ? ((wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + AW'(1)) : wr_ff;
      rd_in    = pop ? ((rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + AW'(1)) : rd_ff;
      count_in = count_ff + NW'(push) - NW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/clcs_back.sv
`timescale 1ns / 1ps
`default_nettype none

module clcs_back #(
   parameter int MAX_WIDTH = clcs_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                head_valid,
   input  wire clcs_pkg::entry_type head,
   output logic                     pop,
   clcs_rsp_if.source               rsp
);

   localparam int PCW = $clog2(MAX_WIDTH / 2 + 4);

   // sample and chroma windows, newest first
   logic [7:0]        cw_ff [5];
   logic signed [7:0] ch_ff [7];
   logic [PCW-1:0]    pc_ff;
   logic [1:0]        fcnt_ff, fcnt_in;

   logic       a_valid_ff, a_last_ff, a_colour_ff;
   logic [8:0] a_j_ff;

   logic              b_valid_ff, b_last_ff, b_colour_ff;
   logic signed [11:0] b_sum_ff;
   logic [7:0]        b_s_ff;
   logic signed [7:0] b_c_ff;
   logic [8:0]        b_j_ff;

   logic              out_valid_ff, out_last_ff, out_colour_ff;
   logic [8:0]        out_j_ff;
   logic [7:0]        out_y_ff, out_y_in;
   logic signed [7:0] out_c_ff;

   logic               adv, go, emit_now, last_now;
   logic [7:0]         cw_e [5];
   logic signed [7:0]  ch_e [7];
   logic [PCW-1:0]     pc_e;
   logic signed [10:0] d, q, qn;
   logic signed [7:0]  c_new;
   logic [8:0]         j_now;
   logic signed [11:0] sum;
   logic signed [8:0]  avg, avg_s;
   logic signed [10:0] y;

   assign adv = !out_valid_ff || rsp.ready;
   assign go  = adv && head_valid;

   always_comb begin
      for (int i = 0; i < 5; i++) begin
         cw_e[i] = head.first ? clcs_pkg::BLANK_SAMPLE : cw_ff[i];
      end
      for (int i = 0; i < 7; i++) begin
         ch_e[i] = head.first ? 8'sd0 : ch_ff[i];
      end
      pc_e = head.first ? '0 : pc_ff;

      d  = 11'sd2 + $signed({2'b00, cw_e[0], 1'b0}) - $signed({3'b000, cw_e[1]})
           - $signed({3'b000, head.sample});
      q  = d[10] ? ((d + 11'sd3) >>> 2) : (d >>> 2);
      qn = pc_e[0] ? q : -q;
      if (qn > $signed(11'(clcs_pkg::CHROMA_LIMIT))) begin
         c_new = 8'(clcs_pkg::CHROMA_LIMIT);
      end else if (qn < -$signed(11'(clcs_pkg::CHROMA_LIMIT))) begin
         c_new = -8'(clcs_pkg::CHROMA_LIMIT);
      end else begin
         c_new = qn[7:0];
      end
      if (head.flush) begin
         c_new = 8'sd0;
      end

      emit_now = head.flush || (pc_e >= PCW'(3));
      last_now = head.flush && (fcnt_ff == 2'd2);
      j_now    = 9'(pc_e - PCW'(3));
      pop      = go && (!head.flush || (fcnt_ff == 2'd2));
      fcnt_in  = (head.flush && go) ? ((fcnt_ff == 2'd2) ? 2'd0 : fcnt_ff + 2'd1) : fcnt_ff;

      sum = 12'sd4 + 12'(ch_ff[3]);
      for (int i = 0; i < 7; i++) begin
         sum = sum + 12'(ch_ff[i]);
      end

      avg   = 9'(b_sum_ff >>> 3);
      avg_s = b_j_ff[0] ? avg : -avg;
      y     = $signed({3'b000, b_s_ff}) - 11'(avg_s);
      if (y < $signed(11'(clcs_pkg::LUMA_MIN))) begin
         out_y_in = 8'(clcs_pkg::LUMA_MIN);
      end else if (y > $signed(11'(clcs_pkg::LUMA_MAX))) begin
         out_y_in = 8'(clcs_pkg::LUMA_MAX);
      end else begin
         out_y_in = y[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         cw_ff[0] <= head.sample;
         for (int i = 1; i < 5; i++) begin
            cw_ff[i] <= cw_e[i-1];
         end
         ch_ff[0] <= c_new;
         for (int i = 1; i < 7; i++) begin
            ch_ff[i] <= ch_e[i-1];
         end
      end
      if (adv) begin
         a_j_ff        <= j_now;
         a_last_ff     <= last_now;
         a_colour_ff   <= head.colour;
         b_sum_ff      <= sum;
         b_s_ff        <= cw_ff[4];
         b_c_ff        <= ch_ff[3];
         b_j_ff        <= a_j_ff;
         b_last_ff     <= a_last_ff;
         b_colour_ff   <= a_colour_ff;
         out_j_ff      <= b_j_ff;
         out_y_ff      <= out_y_in;
         out_c_ff      <= b_c_ff;
         out_last_ff   <= b_last_ff;
         out_colour_ff <= b_colour_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= '0;
         fcnt_ff      <= 2'd0;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         fcnt_ff <= fcnt_in;
         if (go) begin
            pc_ff <= pc_e + PCW'(1);
         end
         if (adv) begin
            a_valid_ff   <= go && emit_now;
            b_valid_ff   <= a_valid_ff;
            out_valid_ff <= b_valid_ff;
         end
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.pair_position = out_j_ff;
   assign rsp.luma_code     = out_y_ff;
   assign rsp.chroma_value  = out_c_ff;
   assign rsp.colour_mode   = out_colour_ff;
   assign rsp.last          = out_last_ff;

endmodule

`default_nettype wire

>>> sv/composite_line_luma_chroma_split.sv
`timescale 1ns / 1ps
`default_nettype none

// Splits one line of palette-indexed pixels into luma and chroma per pixel pair.
// A pixel word is taken every clock while the four-entry queue between the front
// end (palette lookup, pairing, line counting) and the back end (chroma high-pass,
// seven-tap luma separation) has room, so the sustained rate is one pixel per
// cycle. The back end retires one composite sample per cycle unless a stalled
// response holds it; a pair's result passes the a, b and output registers after
// its sample enters the back end and is issued four pairs late, and the last
// pixel of a line releases the final three results. Line width and zigzag offset
// are sampled at the first pixel of each line; the palette applies at once.

module composite_line_luma_chroma_split #(
   parameter int MAX_WIDTH = clcs_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   clcs_req_if.sink                                 req_bus,
   clcs_rsp_if.source                               rsp_bus,
   input  wire logic                                csr_write_enable,
   input  wire logic [clcs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [clcs_pkg::PALETTE_BITS-1:0]   csr_write_data
);

   clcs_pkg::cfg_type   cfg_ff;
   clcs_pkg::entry_type push_data, head;
   logic                push, full, pop, head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.palette    <= '0;
         cfg_ff.line_width <= clcs_pkg::LINE_WIDTH_BITS'(clcs_pkg::MIN_WIDTH);
         cfg_ff.zigzag     <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            clcs_pkg::REG_PALETTE: begin
               cfg_ff.palette <= csr_write_data;
            end
            clcs_pkg::REG_LINE_WIDTH: begin
               cfg_ff.line_width <= csr_write_data[clcs_pkg::LINE_WIDTH_BITS-1:0];
            end
            clcs_pkg::REG_ZIGZAG: begin
               cfg_ff.zigzag <= csr_write_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   clcs_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .cfg         (cfg_ff),
      .queue_full  (full),
      .entry_valid (push),
      .entry       (push_data)
   );

   clcs_queue #(.DEPTH(clcs_pkg::QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   clcs_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp        (rsp_bus)
   );

endmodule

`default_nettype wire
